### hw/rtl/jsve_pkg.sv
// Package for the JSON string value extractor.
// Payload structs, phase encoding, configuration register indexes, character and UTF-8 codes and the hex helper.
// No dependencies.
package jsve_pkg;

  localparam int KEY_MAX_DEF = 8;
  localparam int CFG_IDX_W   = 1;
  localparam int CFG_DATA_W  = 64;
  localparam int KEY_LEN_W   = 4;
  localparam int GRP_DEPTH   = 4;

  localparam logic [CFG_IDX_W-1:0] REG_KEY_BYTES  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_LENGTH = 1'b1;

  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_COLON  = 8'h3A;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_N      = 8'h6E;
  localparam logic [7:0] CH_R      = 8'h72;
  localparam logic [7:0] CH_T      = 8'h74;
  localparam logic [7:0] CH_U      = 8'h75;

  localparam logic [15:0] UTF8_2B_MIN = 16'h0080;
  localparam logic [15:0] UTF8_3B_MIN = 16'h0800;
  localparam logic [7:0]  UTF8_LEAD2  = 8'hC0;
  localparam logic [7:0]  UTF8_LEAD3  = 8'hE0;
  localparam logic [7:0]  UTF8_CONT   = 8'h80;
  localparam logic [5:0]  UTF8_MASK   = 6'h3F;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_text;
  } text_t;

  typedef struct packed {
    logic [7:0] value_byte;
    logic       has_byte;
    logic       found;
    logic       final_res;
  } res_t;

  typedef enum logic [6:0] {
    PH_SEARCH = 7'b0000001,
    PH_COLON  = 7'b0000010,
    PH_QUOTE  = 7'b0000100,
    PH_VALUE  = 7'b0001000,
    PH_ESC    = 7'b0010000,
    PH_HEX    = 7'b0100000,
    PH_DONE   = 7'b1000000
  } phase_t;

  // non-hex characters count as zero
  function automatic logic [3:0] hex_value(input logic [7:0] h);
    logic [3:0] v;
    v = 4'd0;
    if (h >= 8'h30 && h <= 8'h39) v = 4'(h - 8'h30);
    else if (h >= 8'h61 && h <= 8'h66) v = 4'(h - 8'h57);
    else if (h >= 8'h41 && h <= 8'h46) v = 4'(h - 8'h37);
    return v;
  endfunction

endpackage

### hw/rtl/json_string_value_extractor.sv
// Input transfers are registered in the input register, their results in the result group.
// Throughput: one byte per cycle while each byte yields at most one result and res_ready
// is held; a byte that yields more (unicode escape, end of text) makes the next byte with
// results wait while the single result port drains the result group one entry per cycle.
// Reset (rst, synchronous): key cleared, search rearmed, input and result stages emptied.
// Top level of the JSON string value extractor; depends on jsve_pkg.
module json_string_value_extractor #(
  parameter int KEY_MAX = jsve_pkg::KEY_MAX_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            text_valid,
  output logic                            text_ready,
  input  jsve_pkg::text_t                 text_item,
  output logic                            res_valid,
  input  logic                            res_ready,
  output jsve_pkg::res_t                  res_item,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [jsve_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [jsve_pkg::CFG_DATA_W-1:0] cfg_data
);
  import jsve_pkg::*;

  localparam int WIN  = KEY_MAX + 2;
  localparam int FW   = $clog2(WIN + 1);
  localparam int MI_W = $clog2(KEY_MAX + 1);
  localparam logic [KEY_LEN_W-1:0] KEY_MAX_L = KEY_LEN_W'(KEY_MAX);

  logic [CFG_DATA_W-1:0] key_bytes;
  logic [KEY_LEN_W-1:0]  key_length;

  logic        s1_valid;
  text_t       s1_item;
  phase_t      phase, phase_next;
  logic [7:0]  win [WIN];
  logic [7:0]  win_next [WIN];
  logic [FW-1:0] fill, fill_next;
  logic [15:0] acc, acc_next;
  logic [2:0]  hcnt, hcnt_next;

  res_t        grp [GRP_DEPTH];
  res_t        grp_new [GRP_DEPTH];
  logic [2:0]  grp_cnt, grp_rd;
  logic [2:0]  nres;
  logic        grp_can_load;
  logic        s1_go;

  // search path values
  logic [7:0]    win_sh [WIN];
  logic [FW-1:0] fill_sh;
  logic [KEY_MAX:0] mk;
  logic [KEY_LEN_W-1:0] klen;
  logic          match;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      key_bytes  <= '0;
      key_length <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_KEY_BYTES:  key_bytes  <= cfg_data;
        REG_KEY_LENGTH: key_length <= cfg_data[KEY_LEN_W-1:0];
        default: ;
      endcase
    end
  end

  // window shift and needle compare, one candidate per key length
  always_comb begin
    int ki;
    logic ok;
    for (int i = 0; i < WIN - 1; i++) win_sh[i] = win[i+1];
    win_sh[WIN-1] = s1_item.data_byte;
    fill_sh = (fill < FW'(WIN)) ? fill + FW'(1) : fill;
    for (int k = 0; k <= KEY_MAX; k++) begin
      ok = (fill_sh >= FW'(k + 2)) && (win_sh[WIN-2-k] == CH_QUOTE) &&
           (win_sh[WIN-1] == CH_QUOTE);
      for (int j = 1; j <= KEY_MAX; j++) begin
        ki = (j <= k) ? (k - j) : 0;
        if (j <= k && win_sh[WIN-1-j] != key_bytes[8*ki +: 8]) ok = 1'b0;
      end
      mk[k] = ok;
    end
    klen  = (key_length > KEY_MAX_L) ? KEY_MAX_L : key_length;
    match = mk[klen[MI_W-1:0]];
  end

  always_comb begin
    logic [7:0]  b;
    logic        last;
    logic        ws;
    logic [1:0]  nb;
    logic [7:0]  e [3];
    logic [15:0] hacc;
    logic [2:0]  hinc;
    logic        fnd;
    b    = s1_item.data_byte;
    last = s1_item.end_of_text;
    ws   = (b == CH_SPACE) || (b == CH_TAB);
    nb   = 2'd0;
    e[0] = 8'h00;
    e[1] = 8'h00;
    e[2] = 8'h00;
    hacc = {acc[11:0], hex_value(b)};
    hinc = hcnt + 3'd1;
    phase_next = phase;
    win_next   = win;
    fill_next  = fill;
    acc_next   = acc;
    hcnt_next  = hcnt;
    fnd        = 1'b0;

    case (phase)
      PH_SEARCH: begin
        win_next  = win_sh;
        fill_next = fill_sh;
        if (match) phase_next = PH_COLON;
      end
      PH_COLON, PH_QUOTE: begin
        if ((phase == PH_COLON) && (b == CH_COLON)) begin
          phase_next = PH_QUOTE;
        end else if ((phase == PH_QUOTE) && (b == CH_QUOTE)) begin
          phase_next = PH_VALUE;
        end else if (!ws) begin
          // restart: the failing byte is the first byte seen
          for (int i = 0; i < WIN; i++) win_next[i] = 8'h00;
          win_next[WIN-1] = b;
          fill_next  = FW'(1);
          phase_next = PH_SEARCH;
        end
      end
      PH_VALUE: begin
        if (b == CH_QUOTE) begin
          phase_next = PH_DONE;
        end else if (b == CH_BSLASH && !last) begin
          phase_next = PH_ESC;
        end else begin
          nb   = 2'd1;
          e[0] = b;
        end
      end
      PH_ESC: begin
        phase_next = PH_VALUE;
        nb = 2'd1;
        case (b)
          CH_N: e[0] = CH_LF;
          CH_R: e[0] = CH_CR;
          CH_T: e[0] = CH_TAB;
          CH_U: begin
            nb         = 2'd0;
            phase_next = PH_HEX;
            acc_next   = '0;
            hcnt_next  = '0;
          end
          default: e[0] = b;
        endcase
      end
      PH_HEX: begin
        if (hinc == 3'd4) begin
          if (hacc < UTF8_2B_MIN) begin
            nb   = 2'd1;
            e[0] = hacc[7:0];
          end else if (hacc < UTF8_3B_MIN) begin
            nb   = 2'd2;
            e[0] = UTF8_LEAD2 | {3'b000, hacc[10:6]};
            e[1] = UTF8_CONT | {2'b00, hacc[5:0] & UTF8_MASK};
          end else begin
            nb   = 2'd3;
            e[0] = UTF8_LEAD3 | {4'b0000, hacc[15:12]};
            e[1] = UTF8_CONT | {2'b00, hacc[11:6] & UTF8_MASK};
            e[2] = UTF8_CONT | {2'b00, hacc[5:0] & UTF8_MASK};
          end
          acc_next   = '0;
          hcnt_next  = '0;
          phase_next = PH_VALUE;
        end else begin
          acc_next  = hacc;
          hcnt_next = hinc;
        end
      end
      PH_DONE: ;
      default: phase_next = PH_SEARCH;
    endcase

    if (last) begin
      fnd = (phase_next == PH_VALUE) || (phase_next == PH_ESC) ||
            (phase_next == PH_HEX) || (phase_next == PH_DONE);
      phase_next = PH_SEARCH;
      for (int i = 0; i < WIN; i++) win_next[i] = 8'h00;
      fill_next = '0;
      acc_next  = '0;
      hcnt_next = '0;
    end

    for (int j = 0; j < GRP_DEPTH; j++) begin
      grp_new[j] = '0;
      if (j < 3 && 2'(j) < nb) begin
        grp_new[j].value_byte = e[j < 3 ? j : 0];
        grp_new[j].has_byte   = 1'b1;
      end else if (last && 3'(j) == {1'b0, nb}) begin
        grp_new[j].found     = fnd;
        grp_new[j].final_res = 1'b1;
      end
    end
    nres = {1'b0, nb} + {2'b00, last};
  end

  assign res_valid    = (grp_rd != grp_cnt);
  assign res_item     = grp[grp_rd[1:0]];
  assign grp_can_load = !res_valid || ((grp_rd + 3'd1 == grp_cnt) && res_ready);
  assign s1_go        = s1_valid && ((nres == 3'd0) || grp_can_load);
  assign text_ready   = !s1_valid || s1_go;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      phase    <= PH_SEARCH;
      fill     <= '0;
      acc      <= '0;
      hcnt     <= '0;
      grp_cnt  <= '0;
      grp_rd   <= '0;
      for (int i = 0; i < WIN; i++) win[i] <= 8'h00;
    end else begin
      if (text_valid && text_ready) s1_valid <= 1'b1;
      else if (s1_go) s1_valid <= 1'b0;

      if (s1_go) begin
        phase <= phase_next;
        win   <= win_next;
        fill  <= fill_next;
        acc   <= acc_next;
        hcnt  <= hcnt_next;
      end

      if (s1_go && nres != 3'd0) begin
        grp_cnt <= nres;
        grp_rd  <= '0;
      end else if (res_valid && res_ready) begin
        grp_rd <= grp_rd + 3'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (text_valid && text_ready) s1_item <= text_item;
    if (s1_go && nres != 3'd0) grp <= grp_new;
  end

endmodule

### hw/rtl/jsve_chk.sv
// Port-level checks for the JSON string value extractor, bound to the top level.
// Depends on jsve_pkg and json_string_value_extractor.
module jsve_chk (
  input logic           clk,
  input logic           rst,
  input logic           res_valid,
  input logic           res_ready,
  input jsve_pkg::res_t res_item
);

  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(res_item))
    else $error("result changed while stalled");

  a_found_on_final: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_item.found |-> res_item.final_res)
    else $error("found set on a non-final result");

  a_final_no_byte: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_item.final_res |-> !res_item.has_byte && res_item.value_byte == 8'h00)
    else $error("final result carries a byte");

  a_idle_after_reset: assert property (@(posedge clk)
    $past(rst) |-> !res_valid)
    else $error("result offered right after reset");

endmodule

bind json_string_value_extractor jsve_chk u_jsve_chk (.*);

### tb/sv/value_scoreboard.sv
// Scoreboard for the JSON string value extractor testbench.
// Tracks key search, escape decoding and UTF-8 expansion; queues and checks the result stream.
// Depends on jsve_pkg.
`timescale 1ns / 100ps
package extract_check_pkg;
  import jsve_pkg::*;

  localparam int WIN_DEPTH = KEY_MAX_DEF + 2;

  class value_scoreboard;
    logic [CFG_DATA_W-1:0] key_chars;
    logic [KEY_LEN_W-1:0]  key_len;
    phase_t                stage;
    logic [7:0]            window [WIN_DEPTH];
    int                    fill;
    logic [15:0]           code_point;
    int                    digits;
    res_t                  awaited [$];
    int                    errors;

    function new();
      key_chars = '0;
      key_len = '0;
      errors = 0;
      rearm();
    endfunction

    function void clear_window();
      foreach (window[i]) window[i] = 8'h00;
      fill = 0;
    endfunction

    function void rearm();
      clear_window();
      stage = PH_SEARCH;
      code_point = '0;
      digits = 0;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] d);
      if (idx == REG_KEY_BYTES) key_chars = d;
      else key_len = d[KEY_LEN_W-1:0];
    endfunction

    function int pending();
      return awaited.size();
    endfunction

    // shift one byte into the window; 1 when quote, key, quote ends here
    function bit take_search_byte(logic [7:0] b);
      int klen;
      int need;
      int base;
      int i;
      klen = (key_len > KEY_MAX_DEF) ? KEY_MAX_DEF : int'(key_len);
      for (i = 0; i < WIN_DEPTH - 1; i++) window[i] = window[i + 1];
      window[WIN_DEPTH - 1] = b;
      if (fill < WIN_DEPTH) fill++;
      need = klen + 2;
      if (fill < need) return 1'b0;
      base = WIN_DEPTH - need;
      if (window[base] != CH_QUOTE || window[WIN_DEPTH - 1] != CH_QUOTE) return 1'b0;
      for (i = 0; i < klen; i++) begin
        if (window[base + 1 + i] != key_chars[8 * i +: 8]) return 1'b0;
      end
      return 1'b1;
    endfunction

    function void restart(logic [7:0] b);
      clear_window();
      stage = take_search_byte(b) ? PH_COLON : PH_SEARCH;
    endfunction

    function logic [3:0] nibble(logic [7:0] h);
      if (h >= "0" && h <= "9") return 4'(h - "0");
      if (h >= "a" && h <= "f") return 4'(h - "a" + 10);
      if (h >= "A" && h <= "F") return 4'(h - "A" + 10);
      return 4'd0;
    endfunction

    function void emit(logic [7:0] b);
      res_t r;
      r.value_byte = b;
      r.has_byte = 1'b1;
      r.found = 1'b0;
      r.final_res = 1'b0;
      awaited = {awaited, r};
    endfunction

    function void emit_code_point();
      if (code_point < UTF8_2B_MIN) begin
        emit(code_point[7:0]);
      end else if (code_point < UTF8_3B_MIN) begin
        emit(UTF8_LEAD2 | {3'b000, code_point[10:6]});
        emit(UTF8_CONT | {2'b00, code_point[5:0] & UTF8_MASK});
      end else begin
        emit(UTF8_LEAD3 | {4'h0, code_point[15:12]});
        emit(UTF8_CONT | {2'b00, code_point[11:6] & UTF8_MASK});
        emit(UTF8_CONT | {2'b00, code_point[5:0] & UTF8_MASK});
      end
    endfunction

    function void note_text(text_t t);
      logic [7:0] b;
      res_t       r;
      b = t.data_byte;
      case (stage)
        PH_SEARCH: begin
          if (take_search_byte(b)) stage = PH_COLON;
        end
        PH_COLON: begin
          if (b == CH_COLON) stage = PH_QUOTE;
          else if (b != CH_SPACE && b != CH_TAB) restart(b);
        end
        PH_QUOTE: begin
          if (b == CH_QUOTE) stage = PH_VALUE;
          else if (b != CH_SPACE && b != CH_TAB) restart(b);
        end
        PH_VALUE: begin
          if (b == CH_QUOTE) stage = PH_DONE;
          else if (b == CH_BSLASH) begin
            if (t.end_of_text) emit(b);
            else stage = PH_ESC;
          end else emit(b);
        end
        PH_ESC: begin
          stage = PH_VALUE;
          if (b == CH_N) emit(CH_LF);
          else if (b == CH_R) emit(CH_CR);
          else if (b == CH_T) emit(CH_TAB);
          else if (b == CH_U) begin
            stage = PH_HEX;
            code_point = '0;
            digits = 0;
          end else emit(b);
        end
        PH_HEX: begin
          code_point = {code_point[11:0], nibble(b)};
          digits++;
          if (digits >= 4) begin
            emit_code_point();
            code_point = '0;
            digits = 0;
            stage = PH_VALUE;
          end
        end
        default: begin
          stage = PH_DONE;
        end
      endcase
      if (t.end_of_text) begin
        r.value_byte = 8'h00;
        r.has_byte = 1'b0;
        r.found = stage inside {PH_VALUE, PH_ESC, PH_HEX, PH_DONE};
        r.final_res = 1'b1;
        awaited = {awaited, r};
        rearm();
      end
    endfunction

    function void check_res(res_t got);
      res_t want;
      if (awaited.size() == 0) begin
        $error("result transfer with nothing awaited: %h", got);
        errors++;
        return;
      end
      want = awaited[0];
      awaited.delete(0);
      if (got.value_byte !== want.value_byte) begin
        $error("value_byte: expected %h, got %h", want.value_byte, got.value_byte);
        errors++;
      end
      if (got.has_byte !== want.has_byte) begin
        $error("has_byte: expected %b, got %b", want.has_byte, got.has_byte);
        errors++;
      end
      if (got.found !== want.found) begin
        $error("found: expected %b, got %b", want.found, got.found);
        errors++;
      end
      if (got.final_res !== want.final_res) begin
        $error("final_res: expected %b, got %b", want.final_res, got.final_res);
        errors++;
      end
    endfunction
  endclass

endpackage

### tb/sv/testbench.sv
// Top-level testbench for json_string_value_extractor: directed texts, then random texts
// over several key settings, with random idling on both channels; checked by value_scoreboard.
// Depends on jsve_pkg and extract_check_pkg.
`timescale 1ns / 100ps
module testbench;
  import jsve_pkg::*;
  import extract_check_pkg::*;

  localparam int TOTAL_ITEMS = 170;
  localparam int PHASES      = 8;
  localparam int LIMIT       = 300000;
  localparam int SETTLE      = 8;

  logic                  clk        = 1'b0;
  logic                  rst        = 1'b1;
  logic                  text_valid = 1'b0;
  logic                  text_ready;
  text_t                 text_item  = '0;
  logic                  res_valid;
  logic                  res_ready  = 1'b0;
  res_t                  res_item;
  logic                  cfg_valid  = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index  = '0;
  logic [CFG_DATA_W-1:0] cfg_data   = '0;

  value_scoreboard       sb = new();
  logic [7:0]            text_buf [$];
  int                    sent = 0;
  int                    cycle_count = 0;
  bit                    steady = 1'b0;
  logic [CFG_DATA_W-1:0] cur_key = '0;
  logic [KEY_LEN_W-1:0]  cur_len = '0;

  json_string_value_extractor dut (
    .clk        (clk),
    .rst        (rst),
    .text_valid (text_valid),
    .text_ready (text_ready),
    .text_item  (text_item),
    .res_valid  (res_valid),
    .res_ready  (res_ready),
    .res_item   (res_item),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always #5 clk = ~clk;

  function automatic int idle_draw();
    return steady ? 0 : $urandom_range(0, 14);
  endfunction

  function automatic logic [7:0] rand_byte();
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic void add_byte(logic [7:0] b);
    text_buf = {text_buf, b};
  endfunction

  function automatic void add_str(string s);
    for (int i = 0; i < s.len(); i++) text_buf = {text_buf, s[i]};
  endfunction

  function automatic void add_blanks();
    repeat ($urandom_range(0, 2)) add_byte($urandom_range(0, 1) ? CH_SPACE : CH_TAB);
  endfunction

  // leading digits lean to zero so short code points show up
  function automatic logic [7:0] hex_char(bit lead);
    string hexset;
    hexset = "0123456789abcdefABCDEFgz";
    if (lead && $urandom_range(0, 1)) return "0";
    return hexset[$urandom_range(0, 23)];
  endfunction

  function automatic void add_value_piece();
    int sel;
    sel = $urandom_range(0, 9);
    if (sel < 4) add_byte(8'($urandom_range(8'h20, 8'h7e)));
    else if (sel == 4) add_byte(rand_byte());
    else begin
      add_byte(CH_BSLASH);
      case ($urandom_range(0, 7))
        0: add_byte(CH_N);
        1: add_byte(CH_R);
        2: add_byte(CH_T);
        3: add_byte(CH_QUOTE);
        4: add_byte(CH_BSLASH);
        5: add_byte("/");
        6: begin
          add_byte(CH_U);
          add_byte(hex_char(1'b1));
          add_byte(hex_char(1'b1));
          add_byte(hex_char(1'b0));
          add_byte(hex_char(1'b0));
        end
        default: add_byte(rand_byte());
      endcase
    end
  endfunction

  // mostly well-formed key/value texts; some noise, corrupted or truncated
  function automatic void make_text();
    int klen;
    int cut;
    text_buf.delete();
    if ($urandom_range(0, 9) >= 8) begin
      repeat ($urandom_range(1, 6)) add_byte(rand_byte());
      return;
    end
    klen = (cur_len > KEY_MAX_DEF) ? KEY_MAX_DEF : int'(cur_len);
    repeat ($urandom_range(0, 3)) add_byte(rand_byte());
    add_byte(CH_QUOTE);
    for (int k = 0; k < klen; k++) add_byte(cur_key[8 * k +: 8]);
    add_byte(CH_QUOTE);
    add_blanks();
    add_byte(CH_COLON);
    add_blanks();
    add_byte(CH_QUOTE);
    repeat ($urandom_range(0, 5)) add_value_piece();
    if ($urandom_range(0, 4) != 0) add_byte(CH_QUOTE);
    repeat ($urandom_range(0, 2)) add_byte(rand_byte());
    if ($urandom_range(0, 3) == 0) text_buf[$urandom_range(0, text_buf.size() - 1)] = rand_byte();
    if ($urandom_range(0, 3) == 0) begin
      cut = $urandom_range(1, text_buf.size());
      text_buf = text_buf[0:cut-1];
    end
  endfunction

  task automatic push_item(text_t t);
    int gap;
    gap = idle_draw();
    if (gap > 0) begin
      text_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    text_valid <= 1'b1;
    text_item <= t;
    @(posedge clk);
    while (!text_ready) @(posedge clk);
    sb.note_text(t);
    sent++;
  endtask

  task automatic send_text();
    text_t t;
    foreach (text_buf[i]) begin
      t.data_byte = text_buf[i];
      t.end_of_text = (i == text_buf.size() - 1);
      push_item(t);
    end
    text_buf.delete();
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] d);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= d;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.set_reg(idx, d);
  endtask

  task automatic write_key(logic [CFG_DATA_W-1:0] k, logic [KEY_LEN_W-1:0] l);
    write_reg(REG_KEY_BYTES, k);
    write_reg(REG_KEY_LENGTH, {$urandom, $urandom} & ~64'hF | 64'(l));
    cfg_valid <= 1'b0;
    cur_key = k;
    cur_len = l;
  endtask

  task automatic settle();
    text_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // result side
  initial begin
    int gap;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      gap = idle_draw();
      if (gap > 0) begin
        res_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      res_ready <= 1'b1;
      @(posedge clk);
      while (!res_valid) @(posedge clk);
      sb.check_res(res_item);
    end
  end

  initial begin
    while (cycle_count < LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    logic [CFG_DATA_W-1:0] key;
    logic [KEY_LEN_W-1:0]  len;
    int                    goal;
    int                    base;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // empty key after reset: the needle is two quotes
    add_str("\"\" :\"\\n\\u20AC\\x\"Z");
    send_text();
    add_str("\"\":\"\\");
    send_text();
    add_str("\"\"x\"\":\"\\u4");
    send_text();
    settle();

    base = sent;
    for (int p = 0; p < PHASES; p++) begin
      steady = (p % 3 == 1);
      if (p == 0) begin
        key = '1;
        len = '1;
      end else if (p == 1) begin
        key = '0;
        len = '0;
      end else begin
        len = (p == 2) ? KEY_LEN_W'(KEY_MAX_DEF) : KEY_LEN_W'($urandom_range(0, 15));
        if (p == 2 || $urandom_range(0, 1)) begin
          for (int i = 0; i < KEY_MAX_DEF; i++) key[8 * i +: 8] = 8'($urandom_range(97, 122));
        end else key = {$urandom, $urandom};
      end
      write_key(key, len);
      goal = base + (TOTAL_ITEMS - base) * (p + 1) / PHASES;
      do begin
        make_text();
        send_text();
      end while (sent < goal);
      settle();
    end

    if (sb.errors == 0 && sb.pending() == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end

endmodule
